// ----- rtl/bffa_pkg.sv -----
// Package for the first-fit block allocator: payload types, state encodings,
// register indexes and fixed field widths. No dependencies.
package bffa_pkg;

  localparam int REQ_W      = 16;
  localparam int ADDR_W     = 16;
  localparam int BSIZE_W    = 13;
  localparam int BCNT_W     = 11;
  localparam int FIRST_W    = 10;
  localparam int RUN_W      = 11;
  localparam int FREE_W     = 11;
  localparam int DIV_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int HEADER_BYTES    = 2;
  localparam int POOL_META_BYTES = 4;
  localparam int MIN_BSIZE       = 2;
  localparam int RUN_SAT         = 2047;

  localparam logic BLK_FREE = 1'b0;
  localparam logic BLK_USED = 1'b1;

  localparam logic [CFG_DATA_W-1:0] RST_POOL_BASE   = 16'd0;
  localparam logic [BSIZE_W-1:0]    RST_BLOCK_SIZE  = 13'd4;
  localparam logic [BCNT_W-1:0]     RST_BLOCK_COUNT = 11'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE   = 2'd0,
    CFG_BLOCK_SIZE  = 2'd1,
    CFG_BLOCK_COUNT = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OUTCOME_GRANTED   = 2'd0,
    OUTCOME_NO_MEMORY = 2'd1,
    OUTCOME_NO_RUN    = 2'd2
  } outcome_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_SCAN,
    ST_ADDR,
    ST_OUT
  } top_state_e;

  typedef enum logic [1:0] {
    MAP_CLEAR,
    MAP_IDLE,
    MAP_SCAN,
    MAP_MARK
  } map_state_e;

  typedef struct packed {
    logic [REQ_W-1:0] request_bytes;
  } req_t;

  typedef struct packed {
    outcome_e            outcome;
    logic [ADDR_W-1:0]   grant_address;
    logic [FIRST_W-1:0]  first_index;
    logic [RUN_W-1:0]    run_length;
    logic [FREE_W-1:0]   free_left;
  } rsp_t;

  typedef struct packed {
    logic start;
    logic clear;
  } map_ctrl_t;

  typedef struct packed {
    logic clearing;
    logic done;
    logic found;
  } map_stat_t;

endpackage

// ----- rtl/bffa_stream_if.sv -----
// Valid/ready stream interface for the allocator channels.
// Payload type comes in as a parameter; depends on nothing else.
interface bffa_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/bffa_div.sv -----
// Restoring divider, one quotient bit per cycle, for the block count of a request.
// Depends on bffa_pkg.
module bffa_div import bffa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIV_W-1:0]   dividend_i,
  input  logic [BSIZE_W-1:0] divisor_i,
  output logic               done_o,
  output logic [DIV_W-1:0]   quotient_o
);

  localparam int STEP_W = $clog2(DIV_W);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [DIV_W-1:0]   num_q, num_d;
  logic [BSIZE_W-1:0] rem_q, rem_d;
  logic [BSIZE_W-1:0] dvs_q, dvs_d;
  logic [BSIZE_W:0]   trial;
  logic               qbit;

  always_comb begin
    trial  = {rem_q, num_q[DIV_W-1]};
    qbit   = (trial >= {1'b0, dvs_q});
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    num_d  = num_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      num_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      num_d  = {num_q[DIV_W-2:0], qbit};
      rem_d  = qbit ? BSIZE_W'(trial - {1'b0, dvs_q}) : trial[BSIZE_W-1:0];
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = num_q;

endmodule

// ----- rtl/bffa_map.sv -----
// Block used map: one-bit memory with clear pass, first-fit scan and run marking.
// Depends on bffa_pkg.
module bffa_map import bffa_pkg::*; #(
  parameter int MaxBlocks = 1024,
  localparam int IDX_W = $clog2(MaxBlocks),
  localparam int CNT_W = $clog2(MaxBlocks + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  map_ctrl_t        ctrl_i,
  input  logic [CNT_W-1:0] cnt_i,
  input  logic [CNT_W-1:0] need_i,
  output map_stat_t        stat_o,
  output logic [IDX_W-1:0] first_o
);

  logic mem_q [MaxBlocks];

  map_state_e       state_q, state_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] run_q, run_d;
  logic [CNT_W-1:0] left_q, left_d;
  logic [IDX_W-1:0] chk_q, chk_d;
  logic [IDX_W-1:0] first_q, first_d;
  logic             pend_q, pend_d;
  logic             done_q, done_d;
  logic             found_q, found_d;
  logic             rd_data_q;

  logic             rd_more;
  logic [CNT_W-1:0] run_new;
  logic [CNT_W-1:0] run_start;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic             mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;

  assign rd_more   = (ptr_q < cnt_i);
  assign run_new   = rd_data_q ? '0 : run_q + CNT_W'(1);
  assign run_start = CNT_W'(chk_q) + CNT_W'(1) - need_i;

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    run_d   = run_q;
    left_d  = left_q;
    chk_d   = chk_q;
    first_d = first_q;
    pend_d  = pend_q;
    done_d  = 1'b0;
    found_d = found_q;
    if (ctrl_i.clear) begin
      state_d = MAP_CLEAR;
      ptr_d   = '0;
    end else begin
      case (state_q)
        MAP_CLEAR: begin
          ptr_d = ptr_q + CNT_W'(1);
          if (ptr_q == CNT_W'(MaxBlocks - 1)) begin
            state_d = MAP_IDLE;
          end
        end
        MAP_IDLE: begin
          if (ctrl_i.start) begin
            state_d = MAP_SCAN;
            ptr_d   = '0;
            run_d   = '0;
            pend_d  = 1'b0;
          end
        end
        MAP_SCAN: begin
          pend_d = rd_more;
          if (rd_more) begin
            ptr_d = ptr_q + CNT_W'(1);
            chk_d = ptr_q[IDX_W-1:0];
          end
          if (pend_q) begin
            run_d = run_new;
            if (run_new == need_i) begin
              first_d = run_start[IDX_W-1:0];
              ptr_d   = run_start;
              left_d  = need_i;
              pend_d  = 1'b0;
              state_d = MAP_MARK;
            end
          end else if (!rd_more) begin
            state_d = MAP_IDLE;
            done_d  = 1'b1;
            found_d = 1'b0;
          end
        end
        MAP_MARK: begin
          ptr_d  = ptr_q + CNT_W'(1);
          left_d = left_q - CNT_W'(1);
          if (left_q == CNT_W'(1)) begin
            state_d = MAP_IDLE;
            done_d  = 1'b1;
            found_d = 1'b1;
          end
        end
        default: begin
          state_d = MAP_CLEAR;
          ptr_d   = '0;
        end
      endcase
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr_q[IDX_W-1:0];
    mem_wdata = BLK_FREE;
    mem_re    = 1'b0;
    mem_raddr = ptr_q[IDX_W-1:0];
    case (state_q)
      MAP_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = BLK_FREE;
      end
      MAP_SCAN: begin
        mem_re = rd_more;
      end
      MAP_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = BLK_USED;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MAP_CLEAR;
      ptr_q   <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q   <= run_d;
    left_q  <= left_d;
    chk_q   <= chk_d;
    first_q <= first_d;
  end

  assign stat_o.clearing = (state_q == MAP_CLEAR);
  assign stat_o.done     = done_q;
  assign stat_o.found    = found_q;
  assign first_o         = first_q;

endmodule

// ----- rtl/bitmap_first_fit_block_allocator_top.sv -----
// Top level of the first-fit block allocator: registers, free counter, sequencing.
// Depends on bffa_pkg, bffa_stream_if, bffa_div and bffa_map.
//
//   channel  | dir | handshake    | payload
//   req_i    | in  | valid/ready  | req_t: request_bytes
//   rsp_o    | out | valid/ready  | rsp_t: outcome, grant_address, first_index,
//            |     |              |        run_length, free_left
//   cfg      | in  | cfg_we_i     | cfg_idx_i, cfg_wdata_i
//
// A request runs through 17 divider steps, one map read per block in the first-fit
// scan and one map write per granted block. After reset and after each block_count
// write the map is cleared, one block per cycle over all MaxBlocks entries, and no
// request is accepted during that pass.
// A finished result waits in the output register while the next request is taken.
module bitmap_first_fit_block_allocator_top import bffa_pkg::*; #(
  parameter int MaxBlocks = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bffa_stream_if.sink           req_i,
  bffa_stream_if.source         rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int IDX_W  = $clog2(MaxBlocks);
  localparam int CNT_W  = $clog2(MaxBlocks + 1);
  localparam int PROD_W = IDX_W + BSIZE_W;

  function automatic logic [CNT_W-1:0] clamp_count(logic [BCNT_W-1:0] c);
    if (int'(c) > MaxBlocks) begin
      return CNT_W'(MaxBlocks);
    end
    return CNT_W'(c);
  endfunction

  top_state_e state_q, state_d;

  logic [CFG_DATA_W-1:0] pool_base_q;
  logic [BSIZE_W-1:0]    block_size_q;
  logic [BCNT_W-1:0]     block_count_q;
  logic [CNT_W-1:0]      free_q;

  logic [DIV_W-1:0]      need_q;
  logic [IDX_W-1:0]      first_q;
  logic [PROD_W-1:0]     prod_q;
  rsp_t                  res_q;
  rsp_t                  out_q;
  logic                  out_valid_q;

  logic [BSIZE_W-1:0]    bs_eff;
  logic [CNT_W-1:0]      cnt;
  logic [DIV_W-1:0]      dividend;
  logic                  req_fire;
  logic                  out_load;
  logic                  no_memory;
  logic                  cnt_write;
  logic [ADDR_W-1:0]     grant_addr;
  logic [CNT_W:0]        meta_sum;

  logic                  div_start;
  logic                  div_done;
  logic [DIV_W-1:0]      quotient;

  map_ctrl_t             map_ctrl;
  map_stat_t             map_stat;
  logic [IDX_W-1:0]      map_first;

  assign bs_eff    = (block_size_q < BSIZE_W'(MIN_BSIZE)) ? BSIZE_W'(MIN_BSIZE) : block_size_q;
  assign cnt       = clamp_count(block_count_q);
  assign dividend  = DIV_W'(req_i.data.request_bytes) + DIV_W'(HEADER_BYTES)
                   + DIV_W'(bs_eff) - DIV_W'(1);
  assign req_fire  = req_i.valid && req_i.ready;
  assign no_memory = (need_q > DIV_W'(free_q));
  assign cnt_write = cfg_we_i && (cfg_idx_i == CFG_BLOCK_COUNT);
  assign meta_sum  = (CNT_W + 1)'(cnt) + (CNT_W + 1)'(3);
  assign grant_addr = pool_base_q + ADDR_W'(POOL_META_BYTES) + ADDR_W'(meta_sum >> 2)
                    + ADDR_W'(prod_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_d = no_memory ? ST_OUT : ST_SCAN;
      end
      ST_SCAN: begin
        if (map_stat.done) begin
          state_d = map_stat.found ? ST_ADDR : ST_OUT;
        end
      end
      ST_ADDR: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_i.ready    = 1'b0;
    div_start      = 1'b0;
    map_ctrl.start = 1'b0;
    map_ctrl.clear = cnt_write;
    out_load       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_i.ready = !map_stat.clearing;
        div_start   = req_fire;
      end
      ST_CHECK: begin
        map_ctrl.start = !no_memory;
      end
      ST_OUT: begin
        out_load = !out_valid_q || rsp_o.ready;
      end
      default: begin
        req_i.ready = 1'b0;
      end
    endcase
  end

  bffa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (bs_eff),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  bffa_map #(
    .MaxBlocks (MaxBlocks)
  ) u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (map_ctrl),
    .cnt_i   (cnt),
    .need_i  (need_q[CNT_W-1:0]),
    .stat_o  (map_stat),
    .first_o (map_first)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      pool_base_q   <= RST_POOL_BASE;
      block_size_q  <= RST_BLOCK_SIZE;
      block_count_q <= RST_BLOCK_COUNT;
      free_q        <= clamp_count(RST_BLOCK_COUNT);
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_POOL_BASE:   pool_base_q   <= cfg_wdata_i;
          CFG_BLOCK_SIZE:  block_size_q  <= cfg_wdata_i[BSIZE_W-1:0];
          CFG_BLOCK_COUNT: block_count_q <= cfg_wdata_i[BCNT_W-1:0];
          default:         pool_base_q   <= pool_base_q;
        endcase
      end
      if (cnt_write) begin
        free_q <= clamp_count(cfg_wdata_i[BCNT_W-1:0]);
      end else if (state_q == ST_SCAN && map_stat.done && map_stat.found) begin
        free_q <= free_q - need_q[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV && div_done) begin
      need_q           <= quotient;
      res_q.run_length <= (quotient > DIV_W'(RUN_SAT)) ? RUN_W'(RUN_SAT) : quotient[RUN_W-1:0];
    end
    if (state_q == ST_CHECK && no_memory) begin
      res_q.outcome       <= OUTCOME_NO_MEMORY;
      res_q.grant_address <= '0;
      res_q.first_index   <= '0;
      res_q.free_left     <= FREE_W'(free_q);
    end
    if (state_q == ST_SCAN && map_stat.done) begin
      if (map_stat.found) begin
        first_q <= map_first;
        prod_q  <= PROD_W'(map_first) * PROD_W'(bs_eff);
      end else begin
        res_q.outcome       <= OUTCOME_NO_RUN;
        res_q.grant_address <= '0;
        res_q.first_index   <= '0;
        res_q.free_left     <= FREE_W'(free_q);
      end
    end
    if (state_q == ST_ADDR) begin
      res_q.outcome       <= OUTCOME_GRANTED;
      res_q.grant_address <= grant_addr;
      res_q.first_index   <= FIRST_W'(first_q);
      res_q.free_left     <= FREE_W'(free_q);
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  a_free_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_q <= cnt)
    else $error("free block counter exceeds block count");

  a_run_in_pool: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADDR) |->
      ({1'b0, CNT_W'(first_q)} + {1'b0, need_q[CNT_W-1:0]}) <= {1'b0, cnt})
    else $error("granted run extends past the pool");

  a_free_debit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADDR) |-> (free_q + need_q[CNT_W-1:0] == $past(free_q)))
    else $error("free counter not debited by the run length");

  a_refusal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_o.valid && rsp_o.data.outcome != OUTCOME_GRANTED) |->
      (rsp_o.data.grant_address == '0 && rsp_o.data.first_index == '0))
    else $error("refused transaction carries an address");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for bitmap_first_fit_block_allocator_top: queues allocation
// requests, writes the pool registers between phases and predicts every answer.
// Depends on bffa_pkg, bffa_stream_if and the allocator RTL.
module testbench;
  import bffa_pkg::*;

  localparam int MAX_BLOCKS     = 1024;
  localparam int RANDOM_ITEMS   = 280;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = 2200;
  localparam int MAX_REPORTS    = 200;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  bffa_stream_if #(.T(req_t)) req_if ();
  bffa_stream_if #(.T(rsp_t)) rsp_if ();

  bitmap_first_fit_block_allocator_top #(.MaxBlocks(MAX_BLOCKS)) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Pool state as the allocator should hold it
  logic [CFG_DATA_W-1:0] pool_base;
  logic [BSIZE_W-1:0]    block_size;
  logic [BCNT_W-1:0]     block_count;
  logic [MAX_BLOCKS-1:0] block_map;
  int unsigned           free_blocks;

  req_t request_q[$];
  rsp_t expected_answers[$];
  rsp_t want;
  bit   req_busy;
  bit   idle_on;
  int   req_gap;
  int   rsp_gap;
  int   stall_cycles;
  int   error_count;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned usable_size();
    return (block_size < MIN_BSIZE) ? MIN_BSIZE : block_size;
  endfunction

  function automatic int unsigned usable_count();
    return (block_count > MAX_BLOCKS) ? MAX_BLOCKS : block_count;
  endfunction

  function automatic void reload_pool();
    block_map   = '0;
    free_blocks = usable_count();
  endfunction

  function automatic rsp_t allocate_blocks(logic [REQ_W-1:0] bytes);
    int unsigned total, bsz, cnt, need, run, first, idx;
    bit found;
    rsp_t r;
    total = bytes + HEADER_BYTES;
    bsz   = usable_size();
    cnt   = usable_count();
    need  = (total + bsz - 1) / bsz;
    run   = 0;
    first = 0;
    idx   = 0;
    found = 1'b0;
    r     = '0;
    r.outcome = OUTCOME_GRANTED;
    if (total > free_blocks * bsz) begin
      r.outcome = OUTCOME_NO_MEMORY;
    end else begin
      while (!found && idx < cnt) begin
        run = (block_map[idx] == BLK_USED) ? 0 : run + 1;
        if (run == need) begin
          first = idx + 1 - need;
          found = 1'b1;
        end
        idx++;
      end
      if (found) begin
        for (idx = first; idx < first + need; idx++) begin
          block_map[idx] = BLK_USED;
        end
        free_blocks    -= need;
        r.grant_address = ADDR_W'(pool_base + POOL_META_BYTES + (cnt + 3) / 4 + first * bsz);
        r.first_index   = FIRST_W'(first);
      end else begin
        r.outcome = OUTCOME_NO_RUN;
      end
    end
    r.run_length = RUN_W'((need > RUN_SAT) ? RUN_SAT : need);
    r.free_left  = FREE_W'(free_blocks);
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (error_count < MAX_REPORTS) begin
      $display("%0t ns: MISMATCH %s", $time, msg);
    end
    error_count++;
  endtask

  task automatic queue_request(logic [REQ_W-1:0] bytes);
    req_t item;
    item.request_bytes = bytes;
    request_q.push_back(item);
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || req_busy || expected_answers.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_POOL_BASE: begin
        pool_base = val;
      end
      CFG_BLOCK_SIZE: begin
        block_size = val[BSIZE_W-1:0];
      end
      CFG_BLOCK_COUNT: begin
        block_count = val[BCNT_W-1:0];
        reload_pool();
      end
      default: begin
      end
    endcase
  endtask

  // Request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_busy = 1'b0;
      req_gap  = 0;
    end else begin
      if (req_busy && req_if.ready) begin
        expected_answers.push_back(allocate_blocks(req_if.data.request_bytes));
        req_busy = 1'b0;
        req_gap  = idle_on ? $urandom_range(0, 6) : 0;
      end else if (!req_busy && req_gap > 0) begin
        req_gap--;
      end
      if (!req_busy && req_gap == 0 && request_q.size() != 0) begin
        req_if.data <= request_q.pop_front();
        req_busy = 1'b1;
      end
    end
    req_if.valid <= req_busy;
  end

  // Answer monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_gap = 0;
    end else if (rsp_if.valid && rsp_if.ready) begin
      if (expected_answers.size() == 0) begin
        report_mismatch($sformatf("answer with no request outstanding, outcome %0d",
                                  rsp_if.data.outcome));
      end else begin
        want = expected_answers.pop_front();
        if (rsp_if.data.outcome !== want.outcome)
          report_mismatch($sformatf("outcome got %0d expected %0d",
                                    rsp_if.data.outcome, want.outcome));
        if (rsp_if.data.grant_address !== want.grant_address)
          report_mismatch($sformatf("grant_address got %h expected %h",
                                    rsp_if.data.grant_address, want.grant_address));
        if (rsp_if.data.first_index !== want.first_index)
          report_mismatch($sformatf("first_index got %0d expected %0d",
                                    rsp_if.data.first_index, want.first_index));
        if (rsp_if.data.run_length !== want.run_length)
          report_mismatch($sformatf("run_length got %0d expected %0d",
                                    rsp_if.data.run_length, want.run_length));
        if (rsp_if.data.free_left !== want.free_left)
          report_mismatch($sformatf("free_left got %0d expected %0d",
                                    rsp_if.data.free_left, want.free_left));
      end
      rsp_gap = idle_on ? $urandom_range(0, 6) : 0;
    end else if (rsp_gap > 0) begin
      rsp_gap--;
    end
    rsp_if.ready <= rst_ni && rsp_gap == 0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (req_if.valid && req_if.ready) ||
        (rsp_if.valid && rsp_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int issued, phase, burst, k;
    int bsz, cnt, need, slack, val;
    logic [BSIZE_W-1:0] size_pick;
    logic [BCNT_W-1:0]  count_pick;

    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_POOL_BASE;
    cfg_wdata_i  = '0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    idle_on      = 1'b1;
    error_count  = 0;
    pool_base    = RST_POOL_BASE;
    block_size   = RST_BLOCK_SIZE;
    block_count  = RST_BLOCK_COUNT;
    reload_pool();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset pool: saturated need, small grants, exact fill, then no memory
    queue_request(16'hFFFF);
    queue_request(16'd0);
    queue_request(16'd1);
    queue_request(16'd2);
    queue_request(16'd3);
    queue_request(16'd254);
    queue_request(16'd232);
    queue_request(16'd0);
    wait_drained();

    // Size below minimum, count above maximum, address wraps
    write_register(CFG_POOL_BASE, 16'hFFFF);
    write_register(CFG_BLOCK_SIZE, 16'h0001);
    write_register(CFG_BLOCK_COUNT, 16'hFFFF);
    queue_request(16'd0);
    queue_request(16'd2040);
    queue_request(16'd3);
    queue_request(16'd2);
    wait_drained();

    // Empty pool
    write_register(CFG_BLOCK_SIZE, 16'h0000);
    write_register(CFG_BLOCK_COUNT, 16'hF800);
    queue_request(16'hAAAA);
    queue_request(16'd0);
    wait_drained();

    // Largest block size, full-width free check
    write_register(CFG_POOL_BASE, 16'h5A5A);
    write_register(CFG_BLOCK_SIZE, 16'hFFFF);
    write_register(CFG_BLOCK_COUNT, 16'd1024);
    queue_request(16'hFFFF);
    queue_request(16'd8189);
    queue_request(16'h5555);
    wait_drained();

    // Unmapped register index must be ignored
    write_register(CFG_UNUSED, 16'hFFFF);
    write_register(CFG_BLOCK_SIZE, 16'd4096);
    write_register(CFG_BLOCK_COUNT, 16'd1);
    queue_request(16'd4094);
    queue_request(16'd0);
    wait_drained();

    issued = 0;
    phase  = 0;
    while (issued < RANDOM_ITEMS) begin
      wait_drained();
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1) == 1) begin
        write_register(CFG_POOL_BASE, 16'($urandom));
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: size_pick = BSIZE_W'($urandom_range(2, 16));
        6:                size_pick = BSIZE_W'($urandom_range(0, 1));
        7:                size_pick = BSIZE_W'($urandom_range(17, 600));
        8:                size_pick = ($urandom_range(0, 1) == 1) ? 13'd4096 : 13'd8191;
        default:          size_pick = BSIZE_W'($urandom_range(0, 8191));
      endcase
      write_register(CFG_BLOCK_SIZE, {3'($urandom), size_pick});
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: count_pick = BCNT_W'($urandom_range(1, 48));
          6:                count_pick = BCNT_W'($urandom_range(0, 1));
          7:                count_pick = BCNT_W'($urandom_range(49, 300));
          8:                count_pick = BCNT_W'($urandom_range(1024, 2047));
          default:          count_pick = BCNT_W'($urandom_range(0, 2047));
        endcase
        write_register(CFG_BLOCK_COUNT, {5'($urandom), count_pick});
      end
      bsz   = int'(usable_size());
      cnt   = int'(usable_count());
      burst = $urandom_range(8, 24);
      for (k = 0; k < burst; k++) begin
        // hold the sender until the block has answered everything
        if (phase == 1 && k == burst / 2) begin
          wait_drained();
        end
        need  = int'($urandom_range(1, (cnt > 7) ? cnt / 4 : 2));
        slack = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, bsz - 1));
        val   = need * bsz - HEADER_BYTES - slack;
        if ($urandom_range(0, 9) == 0) begin
          val = int'($urandom_range(0, 65535));
        end
        if (val < 0) begin
          val = 0;
        end else if (val > 65535) begin
          val = 65535;
        end
        queue_request(REQ_W'(val));
        issued++;
      end
      phase++;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_answers.size() != 0) begin
      report_mismatch($sformatf("%0d answers never arrived", expected_answers.size()));
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
